>>> rtl/core/fsa_pkg.sv
// Shared types and constants for the flag-setting ALU.
`default_nettype none
package fsa_pkg;
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_CMP = 4'd2, OP_MUL = 4'd3,
    OP_DIV = 4'd4, OP_INC = 4'd5, OP_DEC = 4'd6, OP_NEG = 4'd7,
    OP_AND = 4'd8, OP_OR = 4'd9, OP_XOR = 4'd10, OP_TEST = 4'd11,
    OP_NOT = 4'd12, OP_RDF = 4'd13, OP_WRF = 4'd14, OP_COND = 4'd15
  } op_e;

  typedef enum logic [3:0] {
    CC_AL = 4'd0, CC_Z = 4'd1, CC_NZ = 4'd2, CC_S = 4'd3, CC_NS = 4'd4,
    CC_O = 4'd5, CC_NO = 4'd6, CC_C = 4'd7, CC_NC = 4'd8, CC_UGE = 4'd9,
    CC_ULE = 4'd10, CC_SLT = 4'd11
  } cc_e;

  // flag bit positions
  localparam int unsigned FlagZ = 0;
  localparam int unsigned FlagS = 1;
  localparam int unsigned FlagO = 2;
  localparam int unsigned FlagC = 3;

  // classification made by the front end
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_e;

  function automatic logic cond_holds(input logic [3:0] sel, input logic [3:0] f);
    logic z, s, o, c, r;
    z = f[FlagZ];
    s = f[FlagS];
    o = f[FlagO];
    c = f[FlagC];
    case (sel)
      CC_AL:   r = 1'b1;
      CC_Z:    r = z;
      CC_NZ:   r = !z;
      CC_S:    r = s;
      CC_NS:   r = !s;
      CC_O:    r = o;
      CC_NO:   r = !o;
      CC_C:    r = c;
      CC_NC:   r = !c;
      CC_UGE:  r = !c || z;
      CC_ULE:  r = c || z;
      CC_SLT:  r = s != o;
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/fsa_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module fsa_front import fsa_pkg::*; #(
  parameter int unsigned DataWidth = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [3:0]           op_i,
  input  wire logic [DataWidth-1:0] a_i,
  input  wire logic [DataWidth-1:0] b_i,
  input  wire logic [3:0]           cond_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output logic [3:0]                q_op_o,
  output cls_e                      q_cls_o,
  output logic [DataWidth-1:0]      q_a_o,
  output logic [DataWidth-1:0]      q_b_o,
  output logic [3:0]                q_cond_o
);
  // two-entry queue
  logic [3:0]           op_q   [2];
  cls_e                 cls_q  [2];
  logic [DataWidth-1:0] a_q    [2];
  logic [DataWidth-1:0] b_q    [2];
  logic [3:0]           cond_q [2];
  logic                 wp_q, rp_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;
  cls_e                 cls;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    case (op_i)
      OP_MUL:  cls = CLS_MUL;
      OP_DIV:  cls = CLS_DIV;
      default: cls = CLS_SIMPLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wp_q]   <= op_i;
      cls_q[wp_q]  <= cls;
      a_q[wp_q]    <= a_i;
      b_q[wp_q]    <= b_i;
      cond_q[wp_q] <= cond_i;
    end
  end

  assign q_op_o   = op_q[rp_q];
  assign q_cls_o  = cls_q[rp_q];
  assign q_a_o    = a_q[rp_q];
  assign q_b_o    = b_q[rp_q];
  assign q_cond_o = cond_q[rp_q];
endmodule
`default_nettype wire

>>> rtl/core/fsa_back.sv
// Back end: executes queued requests, owns the flag register and the output register.
`default_nettype none
module fsa_back import fsa_pkg::*; #(
  parameter int unsigned DataWidth = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  output logic                      q_ready_o,
  input  wire logic [3:0]           q_op_i,
  input  wire cls_e                 q_cls_i,
  input  wire logic [DataWidth-1:0] q_a_i,
  input  wire logic [DataWidth-1:0] q_b_i,
  input  wire logic [3:0]           q_cond_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [DataWidth-1:0]      res_o,
  output logic [DataWidth-1:0]      rem_o,
  output logic [3:0]                flags_o,
  output logic                      taken_o,
  output logic                      derr_o
);
  localparam int unsigned CntW = $clog2(DataWidth + 1);
  localparam int unsigned HalfW = (DataWidth + 1) / 2;
  localparam int unsigned PpW = 2 * HalfW;
  localparam int unsigned ProdW = 2 * DataWidth;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MULFIN, ST_DIV, ST_DIVFIN, ST_DONE
  } state_e;

  state_e               state_q;
  logic [3:0]           flags_q;
  logic                 ovalid_q;
  logic [DataWidth-1:0] ores_q, orem_q;
  logic [3:0]           oflags_q;
  logic                 otaken_q, oderr_q;
  logic [DataWidth-1:0] a_q, b_q;
  logic [DataWidth-1:0] quo_q;
  logic [DataWidth-1:0] rw_q;
  logic [CntW-1:0]      cnt_q;
  // multiply: one half-width partial product per step, summed into acc_q
  logic [ProdW-1:0]     acc_q;
  logic [1:0]           mstep_q;

  logic                 out_free, out_load;
  logic [DataWidth-1:0] a, b, msb, sres, sum, dif;
  logic [3:0]           sflags, mflags;
  logic                 stake, cy, bw;
  logic [DataWidth:0]   sh, trial;
  logic [HalfW-1:0]     ma, mb;
  logic [PpW-1:0]       pp;
  logic [ProdW-1:0]     pp_sh;

  assign out_free  = !ovalid_q || out_ready_i;
  assign q_ready_o = (state_q == ST_IDLE) && out_free;
  assign a = q_a_i;
  assign b = q_b_i;
  assign msb = {1'b1, {(DataWidth-1){1'b0}}};
  assign {cy, sum} = {1'b0, a} + {1'b0, b};
  assign {bw, dif} = {1'b0, a} - {1'b0, b};

  // a result lands in the output register this edge
  assign out_load = ((state_q == ST_IDLE) && q_valid_i && out_free &&
                     (q_cls_i != CLS_MUL) && !((q_cls_i == CLS_DIV) && (b != '0))) ||
                    ((state_q == ST_DONE) && out_free);

  function automatic logic [3:0] zs(input logic [DataWidth-1:0] v);
    logic [3:0] f;
    f = 4'd0;
    f[FlagZ] = (v == '0);
    f[FlagS] = v[DataWidth-1];
    return f;
  endfunction

  // simple ops, computed combinationally from the queue head
  always_comb begin
    sres   = '0;
    sflags = flags_q;
    stake  = 1'b0;
    case (q_op_i)
      OP_ADD: begin
        sres = sum;
        sflags = zs(sum);
        sflags[FlagC] = cy;
        sflags[FlagO] = ((a ^ sum) & (b ^ sum) & msb) != '0;
      end
      OP_SUB, OP_CMP: begin
        sres = dif;
        sflags = zs(dif);
        sflags[FlagC] = bw;
        sflags[FlagO] = ((a ^ b) & (a ^ dif) & msb) != '0;
      end
      OP_INC: begin
        sres = a + {{(DataWidth-1){1'b0}}, 1'b1};
        sflags = zs(sres);
        sflags[FlagC] = (sres == '0);
        sflags[FlagO] = (sres == msb);
      end
      OP_DEC: begin
        sres = a - {{(DataWidth-1){1'b0}}, 1'b1};
        sflags = zs(sres);
        sflags[FlagC] = (a == '0);
        sflags[FlagO] = (a == msb);
      end
      OP_NEG: sres = '0 - a;
      OP_AND, OP_TEST: begin
        sres = a & b;
        sflags = zs(sres);
      end
      OP_OR: begin
        sres = a | b;
        sflags = zs(sres);
      end
      OP_XOR: begin
        sres = a ^ b;
        sflags = zs(sres);
      end
      OP_NOT: sres = ~a;
      OP_RDF: sres = {{(DataWidth-4){1'b0}}, flags_q};
      OP_WRF: sflags = a[3:0];
      OP_COND: stake = cond_holds(q_cond_i, flags_q);
      default: sres = '0;
    endcase
  end

  // step 0: lo*lo, 1: lo(a)*hi(b), 2: hi(a)*lo(b), 3: hi*hi
  always_comb begin
    ma = mstep_q[1] ? HalfW'(a_q[DataWidth-1:HalfW]) : a_q[HalfW-1:0];
    mb = mstep_q[0] ? HalfW'(b_q[DataWidth-1:HalfW]) : b_q[HalfW-1:0];
    pp = PpW'(ma) * PpW'(mb);
    case (mstep_q)
      2'd0:    pp_sh = ProdW'(pp);
      2'd3:    pp_sh = ProdW'(pp) << (2 * HalfW);
      default: pp_sh = ProdW'(pp) << HalfW;
    endcase
  end

  always_comb begin
    mflags        = zs(acc_q[DataWidth-1:0]);
    mflags[FlagC] = acc_q[ProdW-1:DataWidth] != '0;
    mflags[FlagO] = acc_q[ProdW-1:DataWidth] != '0;
  end

  assign sh    = {rw_q, a_q[DataWidth-1]};
  assign trial = sh - {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      flags_q  <= 4'd0;
      ovalid_q <= 1'b0;
      ores_q   <= '0;
      orem_q   <= '0;
      oflags_q <= 4'd0;
      otaken_q <= 1'b0;
      oderr_q  <= 1'b0;
      a_q      <= '0;
      b_q      <= '0;
      quo_q    <= '0;
      rw_q     <= '0;
      cnt_q    <= '0;
      acc_q    <= '0;
      mstep_q  <= 2'd0;
    end else begin
      ovalid_q <= out_load || (ovalid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i && out_free) begin
            case (q_cls_i)
              CLS_MUL: begin
                a_q     <= a;
                b_q     <= b;
                acc_q   <= '0;
                mstep_q <= 2'd0;
                state_q <= ST_MUL;
              end
              CLS_DIV: begin
                if (b == '0) begin
                  ores_q   <= '0;
                  orem_q   <= '0;
                  oflags_q <= flags_q;
                  otaken_q <= 1'b0;
                  oderr_q  <= 1'b1;
                end else begin
                  a_q     <= a;
                  b_q     <= b;
                  rw_q    <= '0;
                  quo_q   <= '0;
                  cnt_q   <= CntW'(DataWidth);
                  state_q <= ST_DIV;
                end
              end
              default: begin
                flags_q  <= sflags;
                ores_q   <= sres;
                orem_q   <= '0;
                oflags_q <= sflags;
                otaken_q <= stake;
                oderr_q  <= 1'b0;
              end
            endcase
          end
        end
        ST_MUL: begin
          acc_q   <= acc_q + pp_sh;
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd3) state_q <= ST_MULFIN;
        end
        ST_MULFIN: begin
          ores_q   <= acc_q[DataWidth-1:0];
          oflags_q <= mflags;
          orem_q   <= '0;
          otaken_q <= 1'b0;
          oderr_q  <= 1'b0;
          state_q  <= ST_DONE;
        end
        ST_DIV: begin
          // one restoring step per cycle, MSB first
          a_q <= a_q << 1;
          if (!trial[DataWidth]) begin
            rw_q  <= trial[DataWidth-1:0];
            quo_q <= {quo_q[DataWidth-2:0], 1'b1};
          end else begin
            rw_q  <= sh[DataWidth-1:0];
            quo_q <= {quo_q[DataWidth-2:0], 1'b0};
          end
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) state_q <= ST_DIVFIN;
        end
        ST_DIVFIN: begin
          ores_q   <= quo_q;
          orem_q   <= rw_q;
          oflags_q <= zs(quo_q);
          otaken_q <= 1'b0;
          oderr_q  <= 1'b0;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            flags_q <= oflags_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign res_o   = ores_q;
  assign rem_o   = orem_q;
  assign flags_o = oflags_q;
  assign taken_o = otaken_q;
  assign derr_o  = oderr_q;
endmodule
`default_nettype wire

>>> rtl/core/flag_setting_alu_with_conditions.sv
// Top level of the flag-setting ALU with branch-condition evaluation.
// One request in, one result out, through valid/ready channels. A front end
// takes requests into a two-entry queue; a back end executes them one at a
// time and keeps the 4-bit flag register (zero, sign, overflow, carry).
// A steady stream of simple operations gives one result per cycle while the
// receiver keeps out_ready_i high. Multiply sums four half-width partial
// products, one per cycle, into a double-width accumulator, then passes
// through a wrap-up state and a hand-off state. Divide runs a restoring
// divider at one quotient bit per cycle; a zero divisor returns at once
// with divide_error. Operand bits above DATA_WIDTH are ignored; result bits
// above it read zero.
`default_nettype none
module flag_setting_alu_with_conditions import fsa_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  operation_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  input  wire logic [3:0]  condition_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_o,
  output logic [63:0]      remainder_o,
  output logic [3:0]       flag_bits_o,
  output logic             branch_taken_o,
  output logic             divide_error_o
);
  logic                  q_valid, q_ready;
  logic [3:0]            q_op, q_cond;
  cls_e                  q_cls;
  logic [DATA_WIDTH-1:0] q_a, q_b, res, rem;

  fsa_front #(.DataWidth(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .op_i(operation_i),
    .a_i(operand_a_i[DATA_WIDTH-1:0]),
    .b_i(operand_b_i[DATA_WIDTH-1:0]),
    .cond_i(condition_i),
    .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_op_o(q_op), .q_cls_o(q_cls), .q_a_o(q_a), .q_b_o(q_b), .q_cond_o(q_cond)
  );

  fsa_back #(.DataWidth(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_op_i(q_op), .q_cls_i(q_cls), .q_a_i(q_a), .q_b_i(q_b), .q_cond_i(q_cond),
    .out_valid_o, .out_ready_i,
    .res_o(res), .rem_o(rem), .flags_o(flag_bits_o),
    .taken_o(branch_taken_o), .derr_o(divide_error_o)
  );

  assign result_o    = 64'(res);
  assign remainder_o = 64'(rem);

  // a divide error result never carries a quotient or remainder
  a_derr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> result_o == '0 && remainder_o == '0)
    else $error("divide error with nonzero data");

  // branch flag only on results with no divide error
  a_taken_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && branch_taken_o |-> !divide_error_o)
    else $error("taken and divide error together");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the flag-setting ALU with branch conditions.
`default_nettype none
module tb;
  import fsa_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  operation_i = '0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic [3:0]  condition_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_o;
  logic [63:0] remainder_o;
  logic [3:0]  flag_bits_o;
  logic        branch_taken_o;
  logic        divide_error_o;

  // one expected result
  typedef struct packed {
    logic [63:0] value;
    logic [63:0] rem;
    logic [3:0]  flags;
    logic        taken;
    logic        derr;
  } alu_out_t;

  localparam logic [3:0] FZ = 4'h1;
  localparam logic [3:0] FS = 4'h2;
  localparam logic [3:0] FO = 4'h4;
  localparam logic [3:0] FC = 4'h8;
  localparam logic [63:0] MSB = 64'h8000_0000_0000_0000;

  alu_out_t   pending_results[$];
  logic [3:0] model_flags = '0;   // predicted flag register
  int         err_cnt = 0;
  bit         sender_bursty = 1'b1;
  int         burst_left = 0;

  always #5 clk_i = ~clk_i;

  flag_setting_alu_with_conditions dut (.*);

  function automatic logic [3:0] zs_of(input logic [63:0] v);
    return (v == '0 ? FZ : 4'h0) | (v[63] ? FS : 4'h0);
  endfunction

  function automatic logic branch_test(input logic [3:0] sel, input logic [3:0] f);
    logic z, s, o, c;
    z = f[0]; s = f[1]; o = f[2]; c = f[3];
    case (sel)
      CC_AL:   return 1'b1;
      CC_Z:    return z;
      CC_NZ:   return !z;
      CC_S:    return s;
      CC_NS:   return !s;
      CC_O:    return o;
      CC_NO:   return !o;
      CC_C:    return c;
      CC_NC:   return !c;
      CC_UGE:  return !c || z;
      CC_ULE:  return c || z;
      CC_SLT:  return s != o;
      default: return 1'b0;
    endcase
  endfunction

  // advance the flag model and return what the ALU should produce
  function automatic alu_out_t alu_predict(input logic [3:0] op, input logic [63:0] a,
                                           input logic [63:0] b, input logic [3:0] sel);
    alu_out_t    r;
    logic [3:0]  f;
    logic [127:0] prod;
    r = '0;
    f = model_flags;
    case (op_e'(op))
      OP_ADD: begin
        r.value = a + b;
        f = zs_of(r.value);
        if (r.value < a) f |= FC;
        if (((a ^ r.value) & (b ^ r.value) & MSB) != 0) f |= FO;
      end
      OP_SUB, OP_CMP: begin
        r.value = a - b;
        f = zs_of(r.value);
        if (a < b) f |= FC;
        if (((a ^ b) & (a ^ r.value) & MSB) != 0) f |= FO;
      end
      OP_MUL: begin
        prod = {64'd0, a} * {64'd0, b};
        r.value = prod[63:0];
        f = zs_of(r.value);
        if (prod[127:64] != 0) f |= FC | FO;
      end
      OP_DIV: begin
        if (b == 0) r.derr = 1'b1;
        else begin
          r.value = a / b;
          r.rem = a % b;
          f = zs_of(r.value);
        end
      end
      OP_INC: begin
        r.value = a + 64'd1;
        f = zs_of(r.value);
        if (r.value == 0) f |= FC;
        if (r.value == MSB) f |= FO;
      end
      OP_DEC: begin
        r.value = a - 64'd1;
        f = zs_of(r.value);
        if (a == 0) f |= FC;
        if (a == MSB) f |= FO;
      end
      OP_NEG: r.value = 64'd0 - a;
      OP_AND, OP_TEST: begin r.value = a & b; f = zs_of(r.value); end
      OP_OR: begin r.value = a | b; f = zs_of(r.value); end
      OP_XOR: begin r.value = a ^ b; f = zs_of(r.value); end
      OP_NOT: r.value = ~a;
      OP_RDF: r.value = {60'd0, f};
      OP_WRF: f = a[3:0];
      default: r.taken = branch_test(sel, f);
    endcase
    model_flags = f;
    r.flags = f;
    return r;
  endfunction

  // send one request, with bursty gaps in front of it while sender_bursty is set
  task automatic send_request(input logic [3:0] op, input logic [63:0] a,
                              input logic [63:0] b, input logic [3:0] sel);
    int gap;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    condition_i <= sel;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(alu_predict(op, a, b, sel));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = MSB;
      3: v = MSB - 1;
      4: v = v >> $urandom_range(1, 63);
      5: v = 64'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  // receiver stall pattern: out_ready_i is drawn at random, low two times in ten
  always @(posedge clk_i) begin
    case ($urandom_range(0, 9))
      0, 1:    out_ready_i <= 1'b0;
      default: out_ready_i <= 1'b1;
    endcase
  end

  // checker: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    alu_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", result_o);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o !== exp_r.value) begin
          $error("result exp %h got %h", exp_r.value, result_o); err_cnt++;
        end
        if (remainder_o !== exp_r.rem) begin
          $error("remainder exp %h got %h", exp_r.rem, remainder_o); err_cnt++;
        end
        if (flag_bits_o !== exp_r.flags) begin
          $error("flag_bits exp %h got %h", exp_r.flags, flag_bits_o); err_cnt++;
        end
        if (branch_taken_o !== exp_r.taken) begin
          $error("branch_taken exp %b got %b", exp_r.taken, branch_taken_o); err_cnt++;
        end
        if (divide_error_o !== exp_r.derr) begin
          $error("divide_error exp %b got %b", exp_r.derr, divide_error_o); err_cnt++;
        end
      end
    end
  end

  // arithmetic edge cases: carries, borrows, overflow, wide products, divide
  task automatic test_arith_edges();
    send_request(OP_ADD, '1, 64'd1, CC_AL);
    send_request(OP_ADD, MSB - 1, 64'd1, CC_AL);
    send_request(OP_SUB, 64'd0, 64'd1, CC_AL);
    send_request(OP_CMP, MSB, 64'd1, CC_AL);
    send_request(OP_MUL, '1, '1, CC_AL);
    send_request(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000, CC_AL);
    send_request(OP_MUL, 64'd3, 64'd5, CC_AL);
    send_request(OP_DIV, '1, 64'd7, CC_AL);
    send_request(OP_DIV, 64'd5, 64'd0, CC_AL);   // divide by zero keeps flags
    send_request(OP_DIV, 64'd1, '1, CC_AL);
    send_request(OP_INC, '1, 64'd0, CC_AL);
    send_request(OP_INC, MSB - 1, 64'd0, CC_AL);
    send_request(OP_DEC, 64'd0, 64'd0, CC_AL);
    send_request(OP_DEC, MSB, 64'd0, CC_AL);
  endtask

  // logic ops, flag-preserving ops, flag read/write and all conditions
  task automatic test_logic_and_flags();
    send_request(OP_NEG, MSB, 64'd0, CC_AL);
    send_request(OP_AND, '1, 64'h0F, CC_AL);
    send_request(OP_OR, 64'd0, 64'd0, CC_AL);
    send_request(OP_XOR, '1, 64'd0, CC_AL);
    send_request(OP_TEST, MSB, MSB, CC_AL);
    send_request(OP_NOT, '1, 64'd0, CC_AL);
    for (int f = 0; f < 16; f += 5) begin
      send_request(OP_WRF, {$urandom(), $urandom()} & ~64'hF | 64'(f), 64'd0, CC_AL);
      send_request(OP_RDF, 64'd0, 64'd0, CC_AL);
      for (int c = 0; c < 16; c++) send_request(OP_COND, 64'd0, 64'd0, 4'(c));
    end
  endtask

  // random traffic; flags mostly chained by flag-setting ops before cond
  task automatic test_random_traffic(input int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = 4'($urandom_range(0, 15));
      if (op == OP_DIV && $urandom_range(0, 3) != 0) op = OP_COND;  // keep divides rare
      send_request(op, rand64(), rand64(), 4'($urandom_range(0, 15)));
      if (i == count / 2) wait_drained();  // hold off until all results are back
      if (i == count / 4) sender_bursty = 1'b0;
      if (i == count / 3) sender_bursty = 1'b1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arith_edges();
    test_logic_and_flags();
    test_random_traffic(1850);
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog: fails the run if it has not finished in time
  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
